// ----- hdl/quaternion_to_euler_angles_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle converter
// Shared property shapes, clocked on clk_i and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// Same-cycle implication
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qte_pkg.sv -----
// ---------------------------------------------------------------------------
// qte_pkg
// Widths, constants, state encodings and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package qte_pkg;

  localparam int LEN_W  = 15;   // packet length
  localparam int Q_W    = 16;   // raw component
  localparam int AW     = 16;   // angle result
  localparam int PAW    = 15;   // pitch result
  localparam int SW     = 35;   // sum of squares
  localparam int CIW    = 36;   // CORDIC operand in
  localparam int CW     = 40;   // CORDIC datapath
  localparam int ZW     = 33;   // CORDIC angle accumulator
  localparam int MW     = 32;   // multiplier operand
  localparam int PW     = 2 * MW;
  localparam int RW     = 60;   // radicand
  localparam int RTW    = RW / 2;
  localparam int SQW    = RW + 2;

  localparam int CORDIC_STEPS = 24;
  localparam int IW           = $clog2(CORDIC_STEPS);
  localparam int NORM_BIT     = 29;
  localparam int FRAC_BITS    = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(64);
  localparam logic [LEN_W-1:0] MIN_LEN     = LEN_W'(16);
  localparam logic signed [SW-1:0] S_LIMIT = SW'(1000000000);

  localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(18000 * 65536);
  localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(32768);
  localparam logic signed [ZW-1:0] Z_ANG_MAX   = ZW'(18000);
  localparam logic signed [AW-1:0] PITCH_MAX   = AW'(9000);
  localparam logic signed [AW:0]   FULL_TURN   = (AW+1)'(36000);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_MUL_W, S_SUM, S_CHECK, S_ROLL, S_ROLL_W, S_PCHK,
    S_SS, S_SS_W, S_NN, S_NN_W, S_SQRT, S_SQRT_W, S_PITCH, S_PITCH_W,
    S_YAW, S_YAW_W, S_OUT
  } state_e;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_DONE} cst_e;

  // Component products, computed in this order
  typedef enum logic [3:0] {
    P_XX, P_YY, P_ZZ, P_WW, P_WX, P_YZ, P_WY, P_ZX, P_WZ, P_XY
  } prod_e;

  localparam int NPROD = 10;

  // atan(2^-i) in centidegrees scaled by 2^16, rounded
  function automatic logic signed [ZW-1:0] atan_tab(input logic [IW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = ZW'(294912000);
      5'd1:  v = ZW'(174096719);
      5'd2:  v = ZW'(91987925);
      5'd3:  v = ZW'(46694507);
      5'd4:  v = ZW'(23437865);
      5'd5:  v = ZW'(11730358);
      5'd6:  v = ZW'(5866610);
      5'd7:  v = ZW'(2933484);
      5'd8:  v = ZW'(1466764);
      5'd9:  v = ZW'(733385);
      5'd10: v = ZW'(366693);
      5'd11: v = ZW'(183346);
      5'd12: v = ZW'(91673);
      5'd13: v = ZW'(45837);
      5'd14: v = ZW'(22918);
      5'd15: v = ZW'(11459);
      5'd16: v = ZW'(5730);
      5'd17: v = ZW'(2865);
      5'd18: v = ZW'(1432);
      5'd19: v = ZW'(716);
      5'd20: v = ZW'(358);
      5'd21: v = ZW'(179);
      5'd22: v = ZW'(90);
      5'd23: v = ZW'(45);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/qte_in_if.sv -----
// ---------------------------------------------------------------------------
// qte_in_if
// Report channel: packet length and four raw quaternion components.
// ---------------------------------------------------------------------------
interface qte_in_if;
  logic                     valid;
  logic                     ready;
  logic [14:0]              packet_length;
  logic signed [15:0]       quat_x;
  logic signed [15:0]       quat_y;
  logic signed [15:0]       quat_z;
  logic signed [15:0]       quat_w;

  modport source (output valid, packet_length, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, packet_length, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

// ----- hdl/qte_out_if.sv -----
// ---------------------------------------------------------------------------
// qte_out_if
// Result channel: roll, pitch and yaw in centidegrees plus updated flag.
// ---------------------------------------------------------------------------
interface qte_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       roll_centideg;
  logic signed [14:0]       pitch_centideg;
  logic [15:0]              yaw_centideg;
  logic                     updated;

  modport source (output valid, roll_centideg, pitch_centideg, yaw_centideg,
                  updated, input ready);
  modport sink (input valid, roll_centideg, pitch_centideg, yaw_centideg,
                updated, output ready);
endinterface

// ----- hdl/qte_mul.sv -----
// ---------------------------------------------------------------------------
// qte_mul
// Bit-serial signed multiplier: one multiplier bit per cycle on magnitudes.
// ---------------------------------------------------------------------------
module qte_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [qte_pkg::MW-1:0] a_i,
  input  logic signed [qte_pkg::MW-1:0] b_i,
  output logic                          done_o,
  output logic signed [qte_pkg::PW-1:0] p_o
);

  localparam int CNTW = $clog2(qte_pkg::MW);

  logic                     busy_q;
  logic                     fin_q;
  logic [CNTW-1:0]          cnt_q;
  logic                     neg_q;
  logic [qte_pkg::PW-1:0]   acc_q;
  logic [qte_pkg::PW-1:0]   mc_q;
  logic [qte_pkg::MW-1:0]   mp_q;
  logic [qte_pkg::MW-1:0]   a_mag;
  logic [qte_pkg::MW-1:0]   b_mag;

  assign a_mag = a_i[qte_pkg::MW-1] ? qte_pkg::MW'(-a_i) : qte_pkg::MW'(a_i);
  assign b_mag = b_i[qte_pkg::MW-1] ? qte_pkg::MW'(-b_i) : qte_pkg::MW'(b_i);

  // Control: run one step per multiplier bit, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(qte_pkg::MW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Datapath: add shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      acc_q <= '0;
      mc_q  <= qte_pkg::PW'(a_mag);
      mp_q  <= b_mag;
      neg_q <= a_i[qte_pkg::MW-1] ^ b_i[qte_pkg::MW-1];
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign done_o = fin_q;
  assign p_o    = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ----- hdl/qte_sqrt.sv -----
// ---------------------------------------------------------------------------
// qte_sqrt
// Serial integer square root, one result bit (two radicand bits) per cycle.
// ---------------------------------------------------------------------------
module qte_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [qte_pkg::RW-1:0]      v_i,
  output logic                        done_o,
  output logic [qte_pkg::RTW-1:0]     root_o
);

  localparam int KW = $clog2(qte_pkg::RTW + 1);

  logic                    busy_q;
  logic                    fin_q;
  logic [KW-1:0]           k_q;
  logic [qte_pkg::SQW-1:0] v_q;
  logic [qte_pkg::SQW-1:0] r_q;
  logic [qte_pkg::SQW-1:0] bit_w;
  logic [qte_pkg::SQW-1:0] trial;

  assign bit_w = qte_pkg::SQW'(1) << {k_q, 1'b0};
  assign trial = r_q + bit_w;

  // Control: step the bit position down from the top pair to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      fin_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        k_q    <= KW'(qte_pkg::RTW);
      end else if (busy_q) begin
        k_q <= k_q - 1'b1;
        if (k_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring step, keep the remainder and partial root
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      v_q <= qte_pkg::SQW'(v_i);
      r_q <= '0;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_w;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = fin_q;
  assign root_o = r_q[qte_pkg::RTW-1:0];

endmodule

// ----- hdl/qte_cordic.sv -----
// ---------------------------------------------------------------------------
// qte_cordic
// Iterative vectoring CORDIC atan2 in centidegrees, one micro-rotation a cycle.
// ---------------------------------------------------------------------------
module qte_cordic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [qte_pkg::CIW-1:0] y_i,
  input  logic signed [qte_pkg::CIW-1:0] x_i,
  output logic                           done_o,
  output logic signed [qte_pkg::AW-1:0]  angle_o
);

  qte_pkg::cst_e state_q, state_d;

  logic signed [qte_pkg::CW-1:0] x_q;
  logic signed [qte_pkg::CW-1:0] y_q;
  logic signed [qte_pkg::ZW-1:0] z_q;
  logic [qte_pkg::IW-1:0]        i_q;
  logic signed [qte_pkg::CW-1:0] x_ext;
  logic signed [qte_pkg::CW-1:0] y_ext;
  logic signed [qte_pkg::CW-1:0] y_abs;
  logic                          both_zero;
  logic                          norm_ok;
  logic signed [qte_pkg::CW-1:0] dx;
  logic signed [qte_pkg::CW-1:0] dy;
  logic signed [qte_pkg::ZW-1:0] z_rnd;

  assign x_ext     = qte_pkg::CW'(x_i);
  assign y_ext     = qte_pkg::CW'(y_i);
  assign both_zero = (x_i == '0) && (y_i == '0);
  assign y_abs     = y_q[qte_pkg::CW-1] ? -y_q : y_q;
  assign norm_ok   = (|x_q[qte_pkg::CW-1:qte_pkg::NORM_BIT]) ||
                     (|y_abs[qte_pkg::CW-1:qte_pkg::NORM_BIT]);
  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qte_pkg::C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qte_pkg::C_IDLE: begin
        if (start_i) begin
          state_d = both_zero ? qte_pkg::C_DONE : qte_pkg::C_NORM;
        end
      end
      qte_pkg::C_NORM: begin
        if (norm_ok) begin
          state_d = qte_pkg::C_ITER;
        end
      end
      qte_pkg::C_ITER: begin
        if (i_q == qte_pkg::IW'(qte_pkg::CORDIC_STEPS - 1)) begin
          state_d = qte_pkg::C_DONE;
        end
      end
      qte_pkg::C_DONE: state_d = qte_pkg::C_IDLE;
      default:         state_d = qte_pkg::C_IDLE;
    endcase
  end

  // Datapath: fold into right half plane, normalize, then rotate
  always_ff @(posedge clk_i) begin
    case (state_q)
      qte_pkg::C_IDLE: begin
        i_q <= '0;
        if (start_i) begin
          if (x_i[qte_pkg::CIW-1]) begin
            x_q <= -x_ext;
            y_q <= -y_ext;
            z_q <= y_i[qte_pkg::CIW-1] ? -qte_pkg::Z_HALF_TURN : qte_pkg::Z_HALF_TURN;
          end else begin
            x_q <= x_ext;
            y_q <= y_ext;
            z_q <= '0;
          end
        end
      end
      qte_pkg::C_NORM: begin
        if (!norm_ok) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end
      end
      qte_pkg::C_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + qte_pkg::atan_tab(i_q);
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - qte_pkg::atan_tab(i_q);
        end
        i_q <= i_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Round to centidegrees and clamp to a half turn
  always_comb begin
    z_rnd = (z_q + qte_pkg::Z_ROUND) >>> qte_pkg::FRAC_BITS;
    if (z_rnd > qte_pkg::Z_ANG_MAX) begin
      z_rnd = qte_pkg::Z_ANG_MAX;
    end else if (z_rnd < -qte_pkg::Z_ANG_MAX) begin
      z_rnd = -qte_pkg::Z_ANG_MAX;
    end
  end

  assign angle_o = qte_pkg::AW'(z_rnd);
  assign done_o  = (state_q == qte_pkg::C_DONE);

endmodule

// ----- hdl/quaternion_to_euler_angles_core.sv -----
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Converts a raw orientation quaternion report to roll, pitch and yaw.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  takes one report beat (packet length and x, y, z, w) when valid and
//         ready are both high; ready is high only while the block is idle.
//   out_o gives one result beat per report: roll, pitch, yaw in centidegrees
//         and updated. A rejected report (length outside 16..max, or a sum of
//         squares of zero or of 10^9 and above) returns the held angles with
//         updated low.
//   cfg_we_i / cfg_wdata_i write the maximum packet length (reset 64).
// Work per report: the bit-serial multiplier (ten component products, and
//   two more for the pitch radicand), up to three CORDIC runs (normalize
//   steps plus 24 rotations each) and the 31-step square root. A rejected
//   report stops after the ten products. One report is in work at a time.
// Reset clears the held angles to zero, the result valid flag and the state.
// A stalled receiver holds the result beat; the next report is still taken
//   and computed, and waits for the result register to drain.
// ---------------------------------------------------------------------------
module quaternion_to_euler_angles_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qte_pkg::LEN_W-1:0]     cfg_wdata_i,
  qte_in_if.sink                        in_i,
  qte_out_if.source                     out_o
);

  qte_pkg::state_e state_q, state_d;
  qte_pkg::prod_e  k_q;

  logic [qte_pkg::LEN_W-1:0]       max_len_q;
  logic [qte_pkg::LEN_W-1:0]       len_q;
  logic signed [qte_pkg::Q_W-1:0]  qx_q, qy_q, qz_q, qw_q;
  logic signed [qte_pkg::MW-1:0]   prod_q [qte_pkg::NPROD];
  logic signed [qte_pkg::SW-1:0]   s_q;
  logic signed [qte_pkg::CIW-1:0]  ry_q, rx_q, n_q, wy_q, wx_q;
  logic [qte_pkg::RW-1:0]          ss_q;
  logic [qte_pkg::RW-1:0]          rem_q;
  logic [qte_pkg::RTW-1:0]         root_q;
  logic signed [qte_pkg::AW-1:0]   held_roll_q;
  logic signed [qte_pkg::PAW-1:0]  held_pitch_q;
  logic [qte_pkg::AW-1:0]          held_yaw_q;
  logic                            upd_q;

  logic                            out_valid_q;
  logic signed [qte_pkg::AW-1:0]   out_roll_q;
  logic signed [qte_pkg::PAW-1:0]  out_pitch_q;
  logic [qte_pkg::AW-1:0]          out_yaw_q;
  logic                            out_upd_q;

  logic                            in_fire;
  logic                            out_fire;
  logic                            out_free;
  logic                            rep_ok;
  logic signed [qte_pkg::CIW-1:0]  n_abs;
  logic                            pitch_sat;

  logic                            mul_start, mul_done;
  logic signed [qte_pkg::MW-1:0]   mul_a, mul_b;
  logic signed [qte_pkg::PW-1:0]   mul_p;
  logic                            sqrt_start, sqrt_done;
  logic [qte_pkg::RTW-1:0]         sqrt_root;
  logic                            cord_start, cord_done;
  logic signed [qte_pkg::CIW-1:0]  cord_y, cord_x;
  logic signed [qte_pkg::AW-1:0]   cord_ang;
  logic signed [qte_pkg::AW-1:0]   pitch_clamped;
  logic signed [qte_pkg::AW:0]     yaw_wrapped;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == qte_pkg::S_IDLE);

  assign rep_ok = (len_q >= qte_pkg::MIN_LEN) && (len_q <= max_len_q) &&
                  (s_q != '0) && (s_q < qte_pkg::S_LIMIT);
  assign n_abs     = n_q[qte_pkg::CIW-1] ? -n_q : n_q;
  assign pitch_sat = (n_abs >= qte_pkg::CIW'(s_q));

  // Serial units; the multiplier and the CORDIC are shared between steps
  qte_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  qte_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (rem_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  qte_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (cord_x),
    .done_o  (cord_done),
    .angle_o (cord_ang)
  );

  // Multiplier operand select
  always_comb begin
    mul_a = qte_pkg::MW'(qx_q);
    mul_b = qte_pkg::MW'(qx_q);
    if (state_q == qte_pkg::S_SS) begin
      mul_a = qte_pkg::MW'(s_q);
      mul_b = qte_pkg::MW'(s_q);
    end else if (state_q == qte_pkg::S_NN) begin
      mul_a = qte_pkg::MW'(n_q);
      mul_b = qte_pkg::MW'(n_q);
    end else begin
      unique case (k_q)
        qte_pkg::P_XX: begin mul_a = qte_pkg::MW'(qx_q); mul_b = qte_pkg::MW'(qx_q); end
        qte_pkg::P_YY: begin mul_a = qte_pkg::MW'(qy_q); mul_b = qte_pkg::MW'(qy_q); end
        qte_pkg::P_ZZ: begin mul_a = qte_pkg::MW'(qz_q); mul_b = qte_pkg::MW'(qz_q); end
        qte_pkg::P_WW: begin mul_a = qte_pkg::MW'(qw_q); mul_b = qte_pkg::MW'(qw_q); end
        qte_pkg::P_WX: begin mul_a = qte_pkg::MW'(qw_q); mul_b = qte_pkg::MW'(qx_q); end
        qte_pkg::P_YZ: begin mul_a = qte_pkg::MW'(qy_q); mul_b = qte_pkg::MW'(qz_q); end
        qte_pkg::P_WY: begin mul_a = qte_pkg::MW'(qw_q); mul_b = qte_pkg::MW'(qy_q); end
        qte_pkg::P_ZX: begin mul_a = qte_pkg::MW'(qz_q); mul_b = qte_pkg::MW'(qx_q); end
        qte_pkg::P_WZ: begin mul_a = qte_pkg::MW'(qw_q); mul_b = qte_pkg::MW'(qz_q); end
        qte_pkg::P_XY: begin mul_a = qte_pkg::MW'(qx_q); mul_b = qte_pkg::MW'(qy_q); end
        default: ;
      endcase
    end
  end

  // CORDIC operand select
  always_comb begin
    case (state_q)
      qte_pkg::S_PITCH: begin
        cord_y = n_q;
        cord_x = $signed(qte_pkg::CIW'(root_q));
      end
      qte_pkg::S_YAW: begin
        cord_y = wy_q;
        cord_x = wx_q;
      end
      default: begin
        cord_y = ry_q;
        cord_x = rx_q;
      end
    endcase
  end

  // Pitch clamp and yaw wrap
  always_comb begin
    pitch_clamped = cord_ang;
    if (cord_ang > qte_pkg::PITCH_MAX) begin
      pitch_clamped = qte_pkg::PITCH_MAX;
    end else if (cord_ang < -qte_pkg::PITCH_MAX) begin
      pitch_clamped = -qte_pkg::PITCH_MAX;
    end
    yaw_wrapped = (qte_pkg::AW+1)'(cord_ang);
    if (cord_ang[qte_pkg::AW-1]) begin
      yaw_wrapped = yaw_wrapped + qte_pkg::FULL_TURN;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and unit starts
  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    unique case (state_q)
      qte_pkg::S_IDLE:    if (in_fire) state_d = qte_pkg::S_MUL;
      qte_pkg::S_MUL: begin
        mul_start = 1'b1;
        state_d   = qte_pkg::S_MUL_W;
      end
      qte_pkg::S_MUL_W: begin
        if (mul_done) begin
          state_d = (k_q == qte_pkg::P_XY) ? qte_pkg::S_SUM : qte_pkg::S_MUL;
        end
      end
      qte_pkg::S_SUM:     state_d = qte_pkg::S_CHECK;
      qte_pkg::S_CHECK:   state_d = rep_ok ? qte_pkg::S_ROLL : qte_pkg::S_OUT;
      qte_pkg::S_ROLL: begin
        cord_start = 1'b1;
        state_d    = qte_pkg::S_ROLL_W;
      end
      qte_pkg::S_ROLL_W:  if (cord_done) state_d = qte_pkg::S_PCHK;
      qte_pkg::S_PCHK:    state_d = pitch_sat ? qte_pkg::S_YAW : qte_pkg::S_SS;
      qte_pkg::S_SS: begin
        mul_start = 1'b1;
        state_d   = qte_pkg::S_SS_W;
      end
      qte_pkg::S_SS_W:    if (mul_done) state_d = qte_pkg::S_NN;
      qte_pkg::S_NN: begin
        mul_start = 1'b1;
        state_d   = qte_pkg::S_NN_W;
      end
      qte_pkg::S_NN_W:    if (mul_done) state_d = qte_pkg::S_SQRT;
      qte_pkg::S_SQRT: begin
        sqrt_start = 1'b1;
        state_d    = qte_pkg::S_SQRT_W;
      end
      qte_pkg::S_SQRT_W:  if (sqrt_done) state_d = qte_pkg::S_PITCH;
      qte_pkg::S_PITCH: begin
        cord_start = 1'b1;
        state_d    = qte_pkg::S_PITCH_W;
      end
      qte_pkg::S_PITCH_W: if (cord_done) state_d = qte_pkg::S_YAW;
      qte_pkg::S_YAW: begin
        cord_start = 1'b1;
        state_d    = qte_pkg::S_YAW_W;
      end
      qte_pkg::S_YAW_W:   if (cord_done) state_d = qte_pkg::S_OUT;
      qte_pkg::S_OUT:     if (out_free) state_d = qte_pkg::S_IDLE;
      default:            state_d = qte_pkg::S_IDLE;
    endcase
  end

  // Control registers: config, product index, held angles, result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= qte_pkg::MAX_LEN_RST;
      k_q          <= qte_pkg::P_XX;
      held_roll_q  <= '0;
      held_pitch_q <= '0;
      held_yaw_q   <= '0;
      upd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        k_q <= qte_pkg::P_XX;
      end else if (state_q == qte_pkg::S_MUL_W && mul_done && k_q != qte_pkg::P_XY) begin
        k_q <= qte_pkg::prod_e'(k_q + 1'b1);
      end
      if (state_q == qte_pkg::S_CHECK) begin
        upd_q <= rep_ok;
      end
      if (state_q == qte_pkg::S_ROLL_W && cord_done) begin
        held_roll_q <= cord_ang;
      end
      if (state_q == qte_pkg::S_PCHK && pitch_sat) begin
        held_pitch_q <= n_q[qte_pkg::CIW-1] ? -qte_pkg::PAW'(qte_pkg::PITCH_MAX)
                                             : qte_pkg::PAW'(qte_pkg::PITCH_MAX);
      end
      if (state_q == qte_pkg::S_PITCH_W && cord_done) begin
        held_pitch_q <= qte_pkg::PAW'(pitch_clamped);
      end
      if (state_q == qte_pkg::S_YAW_W && cord_done) begin
        held_yaw_q <= qte_pkg::AW'(yaw_wrapped);
      end
      // drop the beat once taken, then load the next one
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == qte_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      len_q <= in_i.packet_length;
      qx_q  <= in_i.quat_x;
      qy_q  <= in_i.quat_y;
      qz_q  <= in_i.quat_z;
      qw_q  <= in_i.quat_w;
    end
    if (state_q == qte_pkg::S_MUL_W && mul_done) begin
      prod_q[k_q] <= qte_pkg::MW'(mul_p);
    end
    if (state_q == qte_pkg::S_SUM) begin
      s_q <= qte_pkg::SW'(prod_q[qte_pkg::P_WW]) + qte_pkg::SW'(prod_q[qte_pkg::P_XX]) +
             qte_pkg::SW'(prod_q[qte_pkg::P_YY]) + qte_pkg::SW'(prod_q[qte_pkg::P_ZZ]);
    end
    if (state_q == qte_pkg::S_CHECK) begin
      ry_q <= (qte_pkg::CIW'(prod_q[qte_pkg::P_WX]) +
               qte_pkg::CIW'(prod_q[qte_pkg::P_YZ])) <<< 1;
      rx_q <= qte_pkg::CIW'(s_q) - ((qte_pkg::CIW'(prod_q[qte_pkg::P_XX]) +
               qte_pkg::CIW'(prod_q[qte_pkg::P_YY])) <<< 1);
      n_q  <= (qte_pkg::CIW'(prod_q[qte_pkg::P_WY]) -
               qte_pkg::CIW'(prod_q[qte_pkg::P_ZX])) <<< 1;
      wy_q <= (qte_pkg::CIW'(prod_q[qte_pkg::P_WZ]) +
               qte_pkg::CIW'(prod_q[qte_pkg::P_XY])) <<< 1;
      wx_q <= qte_pkg::CIW'(s_q) - ((qte_pkg::CIW'(prod_q[qte_pkg::P_YY]) +
               qte_pkg::CIW'(prod_q[qte_pkg::P_ZZ])) <<< 1);
    end
    if (state_q == qte_pkg::S_SS_W && mul_done) begin
      ss_q <= mul_p[qte_pkg::RW-1:0];
    end
    if (state_q == qte_pkg::S_NN_W && mul_done) begin
      rem_q <= ss_q - mul_p[qte_pkg::RW-1:0];
    end
    if (state_q == qte_pkg::S_SQRT_W && sqrt_done) begin
      root_q <= sqrt_root;
    end
    if (state_q == qte_pkg::S_OUT && out_free) begin
      out_roll_q  <= held_roll_q;
      out_pitch_q <= held_pitch_q;
      out_yaw_q   <= held_yaw_q;
      out_upd_q   <= upd_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.roll_centideg  = out_roll_q;
  assign out_o.pitch_centideg = out_pitch_q;
  assign out_o.yaw_centideg   = out_yaw_q;
  assign out_o.updated        = out_upd_q;

endmodule

// ----- hdl/qte_checker.sv -----
// ---------------------------------------------------------------------------
// qte_checker
// Port-level checks on the converter: beat ordering and held-angle reuse.
// ---------------------------------------------------------------------------
`include "quaternion_to_euler_angles_core_macros.svh"

module qte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_roll_i,
  input logic [14:0] out_pitch_i,
  input logic [15:0] out_yaw_i,
  input logic        out_updated_i
);

  logic        in_fire;
  logic        out_fire;
  logic [1:0]  pend_q;
  logic [15:0] last_roll_q;
  logic [14:0] last_pitch_q;
  logic [15:0] last_yaw_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Track reports in flight and the last delivered angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_roll_q  <= '0;
      last_pitch_q <= '0;
      last_yaw_q   <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire) begin
        last_roll_q  <= out_roll_i;
        last_pitch_q <= out_pitch_i;
        last_yaw_q   <= out_yaw_i;
      end
    end
  end

  `QTE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_yaw_i), "result beat dropped or changed while stalled")
  `QTE_ASSERT_IMP(a_held_reuse, out_valid_i && !out_updated_i, out_roll_i == last_roll_q && out_pitch_i == last_pitch_q && out_yaw_i == last_yaw_q, "rejected report did not return held angles")
  `QTE_ASSERT_IMP(a_in_depth, in_fire, pend_q <= 2'd1, "report accepted with two already in flight")
  `QTE_ASSERT_IMP(a_no_extra, out_valid_i, pend_q != 2'd0, "result beat without a pending report")

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_roll_i    (out_o.roll_centideg),
  .out_pitch_i   (out_o.pitch_centideg),
  .out_yaw_i     (out_o.yaw_centideg),
  .out_updated_i (out_o.updated)
);
